@@ src/rrbr_pkg.sv @@
// Shared constants, register codes and the receiver mount table for the ring receiver block.
package rrbr_pkg;

  localparam int STRENGTH_W        = 16;
  localparam int RING_SIZE         = 8;
  localparam int RING_IDX_W        = 3;
  localparam int ANGLE_W           = 9;
  localparam int RX_PITCH_DEG      = 45;
  localparam int HALF_TURN         = 180;
  localparam int FULL_TURN         = 360;
  localparam int SLOPE_W           = 32;
  localparam int OFFSET_W          = 16;
  localparam int FRAC_W            = 16;
  localparam int RANGE_W           = 16;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 32;
  localparam int HISTORY_DEPTH_DEF = 8;
  // sum of three strengths, and the signed weighted-angle numerator
  localparam int SUM_W             = STRENGTH_W + 2;
  localparam int NUM_W             = 27;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_SLOPE     = 2'd1,
    REG_OFFSET    = 2'd2
  } cfg_reg_t;

  // Mounting angle in degrees of each receiver around the ring
  function automatic logic signed [ANGLE_W-1:0] mount_angle(input logic [RING_IDX_W-1:0] idx);
    logic signed [ANGLE_W-1:0] a;
    unique case (idx)
      3'd0: a = -9'sd90;
      3'd1: a = -9'sd45;
      3'd2: a = 9'sd0;
      3'd3: a = 9'sd45;
      3'd4: a = 9'sd90;
      3'd5: a = 9'sd135;
      3'd6: a = 9'sd180;
      3'd7: a = -9'sd135;
    endcase
    return a;
  endfunction

endpackage

@@ src/rrbr_if.sv @@
// Handshake channel interfaces for strengths, results and register writes.
interface rrbr_in_if
  import rrbr_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [STRENGTH_W-1:0] strength_0;
  logic [STRENGTH_W-1:0] strength_1;
  logic [STRENGTH_W-1:0] strength_2;
  logic [STRENGTH_W-1:0] strength_3;
  logic [STRENGTH_W-1:0] strength_4;
  logic [STRENGTH_W-1:0] strength_5;
  logic [STRENGTH_W-1:0] strength_6;
  logic [STRENGTH_W-1:0] strength_7;

  modport source (
    output valid, strength_0, strength_1, strength_2, strength_3,
           strength_4, strength_5, strength_6, strength_7,
    input  ready
  );
  modport sink (
    input  valid, strength_0, strength_1, strength_2, strength_3,
           strength_4, strength_5, strength_6, strength_7,
    output ready
  );
endinterface

interface rrbr_out_if
  import rrbr_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic                      detected;
  logic signed [ANGLE_W-1:0] bearing;
  logic signed [RANGE_W-1:0] range_cm;

  modport source (output valid, detected, bearing, range_cm, input ready);
  modport sink (input valid, detected, bearing, range_cm, output ready);
endinterface

interface rrbr_cfg_if
  import rrbr_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/rrbr_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle, shared by bearing and range.
module rrbr_div
  import rrbr_pkg::*;
#(
  parameter int NUM_W_P = NUM_W,
  parameter int DEN_W_P = SUM_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NUM_W_P-1:0] num,
  input  logic [DEN_W_P-1:0] den,
  output logic               done,
  output logic [NUM_W_P-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W_P + 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DEN_W_P-1:0] rem_r;
  logic [DEN_W_P-1:0] den_r;
  logic [NUM_W_P-1:0] quo_r;

  logic [DEN_W_P:0]   trial;
  logic [DEN_W_P:0]   diff;
  logic               ge;
  logic [DEN_W_P-1:0] rem_nxt;
  logic [NUM_W_P-1:0] quo_nxt;

  // trial subtract of the shifted partial remainder
  always_comb begin
    trial   = {rem_r, quo_r[NUM_W_P-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? diff[DEN_W_P-1:0] : trial[DEN_W_P-1:0];
    quo_nxt = {quo_r[NUM_W_P-2:0], ge};
  end

  // load on start, then advance one bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(NUM_W_P);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ src/rrbr_hist.sv @@
// Distance history memory: one write port, one registered read port.
module rrbr_hist
  import rrbr_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int ADDR_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic signed [RANGE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic signed [RANGE_W-1:0] rd_data
);

  logic signed [RANGE_W-1:0] mem [HISTORY_DEPTH];
  logic signed [RANGE_W-1:0] rd_data_r;

  // store a new distance
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // register the read word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/ring_receiver_bearing_range.sv @@
// Top level: peak search, bearing and averaged range sequencer for an eight-receiver ring.
//
// One strength vector is taken when the block is idle; in_ch.ready stays low until its result
// has been loaded into the output register, which may still wait for the sink while the next
// vector is taken. The spacing of input transfers is set by the single restoring divider, one
// quotient bit a cycle, used first for the weighted bearing and then for the history mean, and
// by the walk through the history memory, one entry a cycle over its single read port. The mean
// averages n history entries, n being HISTORY_DEPTH once the ring has filled; DIV_W is 26 for
// history depths up to 1024. When nothing exceeds the threshold, the divisions and the walk are
// skipped. The peak search steps once per receiver. The history memory needs no clearing: the
// mean only ever reads entries that have been written.
module ring_receiver_bearing_range
  import rrbr_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  rrbr_in_if.sink   in_ch,
  rrbr_out_if.source out_ch,
  rrbr_cfg_if.sink  cfg_ch
);

  localparam int ADDR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int ACC_W  = RANGE_W + $clog2(HISTORY_DEPTH);
  localparam int DIV_W  = (NUM_W - 1 > ACC_W) ? NUM_W - 1 : ACC_W;
  localparam int DEN_W  = (SUM_W > CNT_W) ? SUM_W : CNT_W;
  localparam int PROD_W = SLOPE_W + STRENGTH_W + 1;
  localparam int T_W    = PROD_W + 1;

  localparam logic signed [NUM_W:0]   STEP_X = (NUM_W + 1)'(RX_PITCH_DEG);
  localparam logic signed [ANGLE_W:0] HALF_X = (ANGLE_W + 1)'(HALF_TURN);
  localparam logic signed [ANGLE_W:0] FULL_X = (ANGLE_W + 1)'(FULL_TURN);
  localparam logic [T_W-1:0]          ROUND_X = T_W'((1 << FRAC_W) - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_CALC, S_OFFS, S_RAW, S_BDIV, S_WALK, S_MSTART, S_MDIV, S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [STRENGTH_W-1:0]      threshold_r;
  logic signed [SLOPE_W-1:0]  slope_r;
  logic signed [OFFSET_W-1:0] offset_r;

  // peak search
  logic [STRENGTH_W-1:0] s_r [RING_SIZE];
  logic [RING_IDX_W-1:0] idx_r;
  logic [RING_IDX_W-1:0] peak_idx_r;
  logic [STRENGTH_W-1:0] best_r;
  logic [STRENGTH_W-1:0] right_r;
  logic [STRENGTH_W-1:0] left_r;
  logic                  found_r;

  // arithmetic
  logic [SUM_W-1:0]         sum_r;
  logic signed [NUM_W-1:0]  num_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [T_W-1:0]    t_r;
  logic                     neg_r;

  // history
  logic [ADDR_W-1:0]       slot_r;
  logic                    full_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        iss_r;
  logic [CNT_W-1:0]        rcv_r;
  logic                    rd_vld_r;
  logic signed [ACC_W-1:0] acc_r;

  // divider handshake
  logic             div_start_r;
  logic [DIV_W-1:0] div_num_r;
  logic [DEN_W-1:0] div_den_r;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;

  // result and output register
  logic                      res_det_r;
  logic signed [ANGLE_W-1:0] res_bearing_r;
  logic signed [RANGE_W-1:0] res_range_r;
  logic                      out_valid_r;
  logic                      out_det_r;
  logic signed [ANGLE_W-1:0] out_bearing_r;
  logic signed [RANGE_W-1:0] out_range_r;

  logic                      in_xfer;
  logic                      out_free;
  logic                      hist_wr_en;
  logic                      hist_rd_en;
  logic signed [RANGE_W-1:0] hist_rd_data;

  logic signed [ANGLE_W-1:0] p_angle;
  logic [SUM_W-1:0]          sum_c;
  logic signed [NUM_W:0]     num_full;
  logic signed [STRENGTH_W:0] nb_diff;
  logic signed [T_W-1:0]     t_c;
  logic signed [T_W-1:0]     t_adj;
  logic signed [T_W-1:0]     q_raw;
  logic signed [RANGE_W-1:0] raw_sat;
  logic [NUM_W-1:0]          num_mag;
  logic [ACC_W-1:0]          acc_mag;
  logic signed [ANGLE_W:0]   b_mag;
  logic signed [ANGLE_W:0]   b_val;
  logic signed [ANGLE_W:0]   b_wrap;
  logic signed [ACC_W:0]     m_mag;
  logic signed [ACC_W:0]     m_val;
  logic [CNT_W-1:0]          count_c;
  logic signed [ACC_W-1:0]   acc_add;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.detected = out_det_r;
  assign out_ch.bearing  = out_bearing_r;
  assign out_ch.range_cm = out_range_r;

  // take register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
      slope_r     <= '0;
      offset_r    <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_THRESHOLD: threshold_r <= cfg_ch.data[STRENGTH_W-1:0];
        REG_SLOPE:     slope_r     <= $signed(cfg_ch.data[SLOPE_W-1:0]);
        REG_OFFSET:    offset_r    <= $signed(cfg_ch.data[OFFSET_W-1:0]);
        default: ;
      endcase
    end
  end

  // weighted numerator: p * (sp + sr + sl) + step * (sr - sl)
  always_comb begin
    p_angle  = mount_angle(peak_idx_r);
    sum_c    = {2'b00, best_r} + {2'b00, right_r} + {2'b00, left_r};
    nb_diff  = $signed({1'b0, right_r}) - $signed({1'b0, left_r});
    num_full = $signed({{(NUM_W + 1 - ANGLE_W){p_angle[ANGLE_W-1]}}, p_angle})
             * $signed({{(NUM_W + 1 - SUM_W){1'b0}}, sum_c})
             + STEP_X * $signed({{(NUM_W - STRENGTH_W){nb_diff[STRENGTH_W]}}, nb_diff});
  end

  // raw distance: truncate toward zero, then saturate
  always_comb begin
    t_c = $signed({prod_r[PROD_W-1], prod_r})
        + $signed({{(T_W - OFFSET_W - FRAC_W){offset_r[OFFSET_W-1]}}, offset_r,
                    {FRAC_W{1'b0}}});
    t_adj = t_r[T_W-1] ? t_r + $signed(ROUND_X) : t_r;
    q_raw = t_adj >>> FRAC_W;
    if (!q_raw[T_W-1] && (q_raw[T_W-1:RANGE_W-1] != '0)) begin
      raw_sat = {1'b0, {(RANGE_W-1){1'b1}}};
    end else if (q_raw[T_W-1] && (q_raw[T_W-1:RANGE_W-1] != '1)) begin
      raw_sat = {1'b1, {(RANGE_W-1){1'b0}}};
    end else begin
      raw_sat = q_raw[RANGE_W-1:0];
    end
  end

  // signs, magnitudes and count for the divider
  always_comb begin
    num_mag = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
    acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    count_c = (full_r || (slot_r == ADDR_W'(HISTORY_DEPTH - 1))) ? CNT_W'(HISTORY_DEPTH)
                                                                 : CNT_W'(slot_r) + CNT_W'(1);
    acc_add = acc_r + $signed({{(ACC_W - RANGE_W){hist_rd_data[RANGE_W-1]}}, hist_rd_data});
  end

  // bearing wrap and mean sign
  always_comb begin
    b_mag  = $signed({1'b0, div_quo[ANGLE_W-1:0]});
    b_val  = neg_r ? -b_mag : b_mag;
    b_wrap = (b_val > HALF_X) ? b_val - FULL_X : b_val;
    m_mag  = $signed({1'b0, div_quo[ACC_W-1:0]});
    m_val  = neg_r ? -m_mag : m_mag;
  end

  assign hist_wr_en = (state_r == S_RAW);
  assign hist_rd_en = (state_r == S_WALK) && (iss_r < count_r);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      full_r      <= 1'b0;
      div_start_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      // drop the output once taken, unless a new result is loaded this cycle
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            s_r[0]  <= in_ch.strength_0;
            s_r[1]  <= in_ch.strength_1;
            s_r[2]  <= in_ch.strength_2;
            s_r[3]  <= in_ch.strength_3;
            s_r[4]  <= in_ch.strength_4;
            s_r[5]  <= in_ch.strength_5;
            s_r[6]  <= in_ch.strength_6;
            s_r[7]  <= in_ch.strength_7;
            best_r  <= threshold_r;
            found_r <= 1'b0;
            idx_r   <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // keep the first strict maximum and its two ring neighbours
          if (s_r[0] > best_r) begin
            best_r     <= s_r[0];
            right_r    <= s_r[1];
            left_r     <= s_r[RING_SIZE-1];
            peak_idx_r <= idx_r;
            found_r    <= 1'b1;
          end
          for (int k = 0; k < RING_SIZE - 1; k++) begin
            s_r[k] <= s_r[k+1];
          end
          s_r[RING_SIZE-1] <= s_r[0];
          idx_r <= idx_r + RING_IDX_W'(1);
          if (idx_r == RING_IDX_W'(RING_SIZE - 1)) begin
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          if (!found_r) begin
            res_det_r     <= 1'b0;
            res_bearing_r <= '0;
            res_range_r   <= '0;
            state_r       <= S_DONE;
          end else begin
            sum_r   <= sum_c;
            num_r   <= num_full[NUM_W-1:0];
            prod_r  <= PROD_W'(slope_r) * PROD_W'($signed({1'b0, best_r}));
            state_r <= S_OFFS;
          end
        end
        S_OFFS: begin
          t_r     <= t_c;
          state_r <= S_RAW;
        end
        S_RAW: begin
          // history written this cycle; start the bearing division
          slot_r      <= (slot_r == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : slot_r + ADDR_W'(1);
          if (slot_r == ADDR_W'(HISTORY_DEPTH - 1)) begin
            full_r <= 1'b1;
          end
          count_r     <= count_c;
          neg_r       <= num_r[NUM_W-1];
          div_num_r   <= DIV_W'(num_mag);
          div_den_r   <= DEN_W'(sum_r);
          div_start_r <= 1'b1;
          state_r     <= S_BDIV;
        end
        S_BDIV: begin
          if (div_done) begin
            res_det_r     <= 1'b1;
            res_bearing_r <= b_wrap[ANGLE_W-1:0];
            iss_r         <= '0;
            rcv_r         <= '0;
            acc_r         <= '0;
            state_r       <= S_WALK;
          end
        end
        S_WALK: begin
          // issue reads, accumulate each word in the cycle after its read
          rd_vld_r <= hist_rd_en;
          if (hist_rd_en) begin
            iss_r <= iss_r + CNT_W'(1);
          end
          if (rd_vld_r) begin
            acc_r <= acc_add;
            rcv_r <= rcv_r + CNT_W'(1);
            if (rcv_r == count_r - CNT_W'(1)) begin
              state_r <= S_MSTART;
            end
          end
        end
        S_MSTART: begin
          neg_r       <= acc_r[ACC_W-1];
          div_num_r   <= DIV_W'(acc_mag);
          div_den_r   <= DEN_W'(count_r);
          div_start_r <= 1'b1;
          state_r     <= S_MDIV;
        end
        S_MDIV: begin
          if (div_done) begin
            res_range_r <= m_val[RANGE_W-1:0];
            state_r     <= S_DONE;
          end
        end
        S_DONE: begin
          // hand the result over once the output register is free
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_det_r     <= res_det_r;
            out_bearing_r <= res_bearing_r;
            out_range_r   <= res_range_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  rrbr_div #(
    .NUM_W_P(DIV_W),
    .DEN_W_P(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start_r),
    .num  (div_num_r),
    .den  (div_den_r),
    .done (div_done),
    .quo  (div_quo)
  );

  rrbr_hist #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .ADDR_W       (ADDR_W)
  ) u_hist (
    .clk    (clk),
    .wr_en  (hist_wr_en),
    .wr_addr(slot_r),
    .wr_data(raw_sat),
    .rd_en  (hist_rd_en),
    .rd_addr(iss_r[ADDR_W-1:0]),
    .rd_data(hist_rd_data)
  );

endmodule

@@ dv/tb.sv @@
// Self-checking bench for the ring receiver bearing and range block.
`timescale 1ns / 1ps

module tb
  import rrbr_pkg::*;
();

  localparam int HISTORY_DEPTH = HISTORY_DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int QUIET_ITEMS   = 200;
  localparam int DRAIN_CYCLES  = 200;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam logic [STRENGTH_W-1:0] STRENGTH_MAX = '1;

  // receiver mounting angles in degrees, index 0 at -90
  localparam int RECEIVER_DEG [RING_SIZE] = '{-90, -45, 0, 45, 90, 135, 180, -135};

  typedef logic [STRENGTH_W-1:0] strength_vec_t [RING_SIZE];

  typedef struct packed {
    logic                      detected;
    logic signed [ANGLE_W-1:0] bearing;
    logic signed [RANGE_W-1:0] range_cm;
  } fix_t;

  // Predicts one bearing fix per strength vector and checks the block's fixes in order
  class fix_scoreboard;
    logic [STRENGTH_W-1:0]      threshold;
    logic signed [SLOPE_W-1:0]  slope;
    logic signed [OFFSET_W-1:0] offset;
    logic signed [RANGE_W-1:0]  distance_ring [HISTORY_DEPTH];
    int                         fill_slot;
    bit                         ring_full;
    fix_t                       pending_fixes [$];
    int                         errors;

    function new();
      threshold = '0;
      slope     = '0;
      offset    = '0;
      fill_slot = 0;
      ring_full = 1'b0;
      errors    = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_THRESHOLD: threshold = data[STRENGTH_W-1:0];
        REG_SLOPE:     slope     = data[SLOPE_W-1:0];
        REG_OFFSET:    offset    = data[OFFSET_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_range(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function int pending();
      return pending_fixes.size();
    endfunction

    // Work out the fix for an accepted vector and queue it
    function void note_vector(strength_vec_t s);
      logic [STRENGTH_W-1:0] best;
      int     peak, left_rx, right_rx, cnt;
      bit     found;
      longint sp, sl, sr, ang, step, total, num, brg, raw, acc;
      fix_t   f;
      best  = threshold;
      peak  = 0;
      found = 1'b0;
      f     = '0;
      // first strict maximum above the threshold wins
      for (int k = 0; k < RING_SIZE; k++) begin
        if (s[k] > best) begin
          best  = s[k];
          peak  = k;
          found = 1'b1;
        end
      end
      if (found) begin
        left_rx  = (peak + RING_SIZE - 1) % RING_SIZE;
        right_rx = (peak + 1) % RING_SIZE;
        sp    = longint'(s[peak]);
        sl    = longint'(s[left_rx]);
        sr    = longint'(s[right_rx]);
        ang   = longint'(RECEIVER_DEG[peak]);
        step  = longint'(RX_PITCH_DEG);
        total = sp + sl + sr;
        num   = sp * ang + sr * (ang + step) + sl * (ang - step);
        brg   = num / total;
        if (brg > HALF_TURN) brg -= FULL_TURN;
        raw = (longint'(slope) * sp + (longint'(offset) <<< FRAC_W)) / (longint'(1) <<< FRAC_W);
        // advance the distance ring
        distance_ring[fill_slot] = RANGE_W'(clamp_range(raw));
        fill_slot++;
        if (fill_slot == HISTORY_DEPTH) begin
          ring_full = 1'b1;
          fill_slot = 0;
        end
        cnt = ring_full ? HISTORY_DEPTH : fill_slot;
        acc = 0;
        for (int k = 0; k < cnt; k++) acc += longint'(distance_ring[k]);
        f.detected = 1'b1;
        f.bearing  = brg[ANGLE_W-1:0];
        f.range_cm = RANGE_W'(clamp_range(acc / longint'(cnt)));
      end
      pending_fixes.push_back(f);
    endfunction

    function void check_fix(fix_t got);
      fix_t exp_fix;
      if (pending_fixes.size() == 0) begin
        errors++;
        $display("%0t: unexpected fix detected=%0b bearing=%0d range_cm=%0d", $time,
                 got.detected, $signed(got.bearing), $signed(got.range_cm));
        return;
      end
      exp_fix = pending_fixes.pop_front();
      if (got.detected !== exp_fix.detected) begin
        errors++;
        $display("%0t: detected expected %0b actual %0b", $time,
                 exp_fix.detected, got.detected);
      end
      if (got.bearing !== exp_fix.bearing) begin
        errors++;
        $display("%0t: bearing expected %0d actual %0d", $time,
                 $signed(exp_fix.bearing), $signed(got.bearing));
      end
      if (got.range_cm !== exp_fix.range_cm) begin
        errors++;
        $display("%0t: range_cm expected %0d actual %0d", $time,
                 $signed(exp_fix.range_cm), $signed(got.range_cm));
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rrbr_in_if  in_ch ();
  rrbr_out_if out_ch ();
  rrbr_cfg_if cfg_ch ();

  fix_scoreboard fixes = new();
  int            idle_pct = 0;
  int            cycle_count = 0;

  ring_receiver_bearing_range #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Check each fix transfer, then pick the next ready with random stall bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      fixes.check_fix('{detected: out_ch.detected, bearing: out_ch.bearing,
                        range_cm: out_ch.range_cm});
    end
    if (stall_left > 0) begin
      stall_left     <= stall_left - 1;
      out_ch.ready   <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      stall_left     <= $urandom_range(0, 7);
      out_ch.ready   <= 1'b0;
    end else begin
      out_ch.ready   <= 1'b1;
    end
  end

  // Offer one strength vector, optionally after an idle burst, and hold until transfer
  task automatic send_vector(input strength_vec_t v);
    if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.strength_0 <= v[0];
    in_ch.strength_1 <= v[1];
    in_ch.strength_2 <= v[2];
    in_ch.strength_3 <= v[3];
    in_ch.strength_4 <= v[4];
    in_ch.strength_5 <= v[5];
    in_ch.strength_6 <= v[6];
    in_ch.strength_7 <= v[7];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    fixes.note_vector(v);
  endtask

  // Drop valid and wait until every queued fix has come back
  task automatic drain_fixes();
    in_ch.valid <= 1'b0;
    while (fixes.pending() != 0) @(posedge clk);
  endtask

  // Write all three registers back to back; valid stays high across the writes
  task automatic apply_settings(input logic [STRENGTH_W-1:0] thr,
                                input logic signed [SLOPE_W-1:0] slope,
                                input logic signed [OFFSET_W-1:0] off);
    cfg_reg_t              regs [3];
    logic [CFG_DATA_W-1:0] vals [3];
    regs = '{REG_THRESHOLD, REG_SLOPE, REG_OFFSET};
    vals = '{{16'h0, thr}, slope, {{16{off[OFFSET_W-1]}}, off}};
    for (int k = 0; k < 3; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[k];
      cfg_ch.data  <= vals[k];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      fixes.set_reg(regs[k], vals[k]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Random strength vector shaped around the current threshold
  function automatic strength_vec_t random_vector(input logic [STRENGTH_W-1:0] thr);
    strength_vec_t v;
    int t, w, pk;
    t = int'(thr);
    for (int k = 0; k < RING_SIZE; k++) v[k] = STRENGTH_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 9))
      5, 6: begin
        // one dominant receiver over a quiet ring
        for (int k = 0; k < RING_SIZE; k++) v[k] = STRENGTH_W'($urandom_range(0, t));
        pk = int'($urandom_range(0, RING_SIZE - 1));
        v[pk] = (t == 65535) ? STRENGTH_MAX : STRENGTH_W'($urandom_range(t + 1, 65535));
      end
      7: begin
        // equal maxima at two receivers
        w = int'($urandom_range(t, 65535));
        for (int k = 0; k < RING_SIZE; k++) v[k] = STRENGTH_W'($urandom_range(0, w));
        v[$urandom_range(0, RING_SIZE - 1)] = STRENGTH_W'(w);
        v[$urandom_range(0, RING_SIZE - 1)] = STRENGTH_W'(w);
      end
      8: begin
        // nothing above the threshold
        for (int k = 0; k < RING_SIZE; k++) v[k] = STRENGTH_W'($urandom_range(0, t));
      end
      9: begin
        for (int k = 0; k < RING_SIZE; k++) begin
          case ($urandom_range(0, 2))
            0: v[k] = '0;
            1: v[k] = STRENGTH_MAX;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    strength_vec_t             v;
    logic [STRENGTH_W-1:0]     thr;
    logic signed [SLOPE_W-1:0] slope;
    logic signed [OFFSET_W-1:0] off;
    int                        rand_sent, phase_len;

    in_ch.valid      <= 1'b0;
    in_ch.strength_0 <= '0;
    in_ch.strength_1 <= '0;
    in_ch.strength_2 <= '0;
    in_ch.strength_3 <= '0;
    in_ch.strength_4 <= '0;
    in_ch.strength_5 <= '0;
    in_ch.strength_6 <= '0;
    in_ch.strength_7 <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_THRESHOLD;
    cfg_ch.data      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 20;

    // reset settings: all-zero ring is not a detection, lone receivers give their own angle
    v = '{default: '0};
    send_vector(v);
    for (int k = 0; k < RING_SIZE; k++) begin
      v = '{default: '0};
      v[k] = 16'd1;
      send_vector(v);
    end
    // full-scale ring: lowest index wins the tie
    v = '{default: STRENGTH_MAX};
    send_vector(v);
    v = '{default: '0};
    v[3] = 16'd500;
    v[5] = 16'd500;
    send_vector(v);
    drain_fixes();

    // peak exactly at the threshold, just above it, and a wrap past the back
    apply_settings(16'd1000, 32'sh7FFF_FFFF, 16'sh7FFF);
    v = '{default: '0};
    v[4] = 16'd1000;
    send_vector(v);
    v[4] = 16'd1001;
    send_vector(v);
    v = '{default: '0};
    v[6] = 16'd1100;
    v[7] = 16'd1100;
    send_vector(v);
    v = '{default: '0};
    v[7] = 16'd5000;
    v[0] = 16'd5000;
    send_vector(v);
    v = '{default: '0};
    v[2] = STRENGTH_MAX;
    v[1] = 16'd1;
    v[3] = 16'd2;
    send_vector(v);
    drain_fixes();

    // most negative slope and offset saturate the distance low
    apply_settings(16'd0, 32'sh8000_0000, 16'sh8000);
    v = '{default: STRENGTH_MAX};
    send_vector(v);
    v = '{default: '0};
    v[5] = 16'd1;
    send_vector(v);
    drain_fixes();

    // top threshold: nothing can be detected
    apply_settings(STRENGTH_MAX, 32'sh0001_0000, 16'sh0000);
    v = '{default: STRENGTH_MAX};
    send_vector(v);
    v = '{default: '0};
    send_vector(v);
    drain_fixes();

    // random phases, each under fresh settings
    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: thr = STRENGTH_W'($urandom_range(0, 255));
        4, 5, 6:    thr = STRENGTH_W'($urandom_range(0, 65535));
        7, 8:       thr = '0;
        default:    thr = STRENGTH_MAX - STRENGTH_W'($urandom_range(0, 1));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: slope = int'($urandom_range(0, 524288)) - 262144;
        5, 6, 7:       slope = $urandom;
        8:             slope = 32'sh7FFF_FFFF;
        default:       slope = 32'sh8000_0000;
      endcase
      off = OFFSET_W'($urandom_range(0, 65535));
      apply_settings(thr, slope, off);
      idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 20;
      phase_len = $urandom_range(20, 150);
      for (int j = 0; j < phase_len && rand_sent < RANDOM_ITEMS; j++) begin
        if (rand_sent >= RANDOM_ITEMS - QUIET_ITEMS) idle_pct = 0;
        send_vector(random_vector(thr));
        rand_sent++;
      end
      drain_fixes();
    end

    // hold quiet to catch any stray fix
    idle_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fixes.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
